@@ src/r2fft_pkg.sv @@
// Shared constants, types and twiddle ROM for the radix-2 FFT block.
package r2fft_pkg;

    localparam int MAX_POINTS_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int TW_SHIFT        = 15;

    localparam logic CFG_SIZE_LOG2    = 1'b0;
    localparam logic CFG_INVERSE_MODE = 1'b1;

    // Control word handed from the front end to the transform engine.
    typedef struct packed {
        logic [2:0] k;
        logic       inv;
    } r2fft_job_t;

    // cos(2*pi*m/64) * 2^15 for m = 0..16.
    function automatic logic signed [16:0] quarter_cos(input logic [4:0] m);
        logic signed [16:0] v;
        unique case (m)
            5'd0:  v = 17'sd32768;
            5'd1:  v = 17'sd32610;
            5'd2:  v = 17'sd32138;
            5'd3:  v = 17'sd31357;
            5'd4:  v = 17'sd30274;
            5'd5:  v = 17'sd28899;
            5'd6:  v = 17'sd27246;
            5'd7:  v = 17'sd25330;
            5'd8:  v = 17'sd23170;
            5'd9:  v = 17'sd20788;
            5'd10: v = 17'sd18205;
            5'd11: v = 17'sd15447;
            5'd12: v = 17'sd12540;
            5'd13: v = 17'sd9512;
            5'd14: v = 17'sd6393;
            5'd15: v = 17'sd3212;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

    // Twiddle cos and sin parts for W^m, m taken modulo 32.
    function automatic logic signed [33:0] twiddle(input logic [4:0] m);
        logic signed [16:0] c;
        logic signed [16:0] s;
        if (m <= 5'd16) begin
            c = quarter_cos(m);
            s = quarter_cos(5'd16 - m);
        end else begin
            c = -quarter_cos(5'd0 - m);
            s = quarter_cos(m - 5'd16);
        end
        return {c, s};
    endfunction

endpackage

@@ src/r2fft_front.sv @@
// Front end: loads samples, tracks the fill count and issues transform jobs.
module r2fft_front
    import r2fft_pkg::*;
#(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int AW = $clog2(MAX_POINTS),
    localparam int KMAX = $clog2(MAX_POINTS)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_real,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_imag,
    input  logic [2:0]                    size_log2,
    input  logic                          inverse_mode,
    input  logic                          eng_busy,
    output logic                          wr_en,
    output logic [AW-1:0]                 wr_addr,
    output logic signed [SAMPLE_BITS-1:0] wr_re,
    output logic signed [SAMPLE_BITS:0]   wr_im,
    output logic                          job_valid,
    output r2fft_job_t                    job
);

    logic [6:0] count_reg, count_next;
    logic [2:0] k_eff;
    logic [6:0] n_pts;
    logic [6:0] count_inc;

    always_comb begin
        if (size_log2 > 3'(KMAX)) k_eff = 3'(KMAX);
        else                      k_eff = size_log2;
        n_pts = 7'd1 << k_eff;
    end

    // The store holds one transform: no loading while the engine owns it.
    assign s_ready   = !eng_busy;
    assign wr_en     = s_valid && s_ready;
    assign wr_addr   = count_reg[AW-1:0];
    assign wr_re     = s_sample_real;
    // Widen by one bit so that negating the most negative sample stays exact.
    assign wr_im     = inverse_mode ? -{s_sample_imag[SAMPLE_BITS-1], s_sample_imag}
                                    : {s_sample_imag[SAMPLE_BITS-1], s_sample_imag};
    assign count_inc = count_reg + 7'd1;
    assign job_valid = wr_en && (count_inc >= n_pts);
    assign job.k     = k_eff;
    assign job.inv   = inverse_mode;

    always_comb begin
        count_next = count_reg;
        if (job_valid)  count_next = '0;
        else if (wr_en) count_next = count_inc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) count_reg <= '0;
        else          count_reg <= count_next;
    end

endmodule

@@ src/r2fft_engine.sv @@
// Transform engine: point store, bit-reverse, butterfly stages and bin output.
module r2fft_engine
    import r2fft_pkg::*;
#(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int AW = $clog2(MAX_POINTS),
    localparam int BW = SAMPLE_BITS + 6
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic signed [SAMPLE_BITS-1:0] wr_re,
    input  logic signed [SAMPLE_BITS:0]   wr_im,
    input  logic                          job_valid,
    input  r2fft_job_t                    job,
    output logic                          busy,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [BW-1:0]          m_bin_real,
    output logic signed [BW-1:0]          m_bin_imag,
    output logic                          m_last_bin
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_BRV  = 7'b0000010,
        ST_RDA  = 7'b0000100,
        ST_RDB  = 7'b0001000,
        ST_MUL  = 7'b0010000,
        ST_WR   = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [BW-1:0] mem_re [MAX_POINTS];
    logic signed [BW-1:0] mem_im [MAX_POINTS];

    r2fft_job_t           job_reg;
    logic [AW:0]          idx_reg;   // generic index (bit-reverse, butterfly, output)
    logic [2:0]           stg_reg;   // stage number, half = 1 << stg
    logic [1:0]           brp_reg;   // bit-reverse sub step
    logic signed [BW-1:0] ar_reg, ai_reg, br_reg, bi_reg;
    logic signed [BW-1:0] tr_reg, ti_reg;
    logic signed [BW+17:0] p_rc_reg, p_is_reg, p_ic_reg, p_rs_reg;
    logic                 mulp_reg;
    logic                 ovalid_reg;
    logic signed [BW-1:0] ore_reg, oim_reg;
    logic                 olast_reg;
    logic                 rd_pend_reg;
    logic [AW-1:0]        rd_addr;
    logic signed [BW-1:0] rd_re_reg, rd_im_reg;

    logic [AW:0]   n_pts;
    logic [AW-1:0] rev_idx;
    logic [AW-1:0] half, addr_a, addr_b, jpos;
    logic [4:0]    tw_m;
    logic signed [16:0] tw_c, tw_s;
    logic          out_free;

    assign n_pts = (AW+1)'(1) << job_reg.k;
    assign half  = AW'(1) << stg_reg;
    assign out_free = !ovalid_reg || m_ready;

    always_comb begin
        rev_idx = '0;
        for (int b = 0; b < AW; b++) begin
            if (b < int'(job_reg.k))
                rev_idx[int'(job_reg.k) - 1 - b] = idx_reg[b];
        end
    end

    // Butterfly index t = group*half + j  -> a = group*2*half + j
    always_comb begin
        jpos   = idx_reg[AW-1:0] & (half - AW'(1));
        addr_a = ((idx_reg[AW-1:0] & ~(half - AW'(1))) << 1) | jpos;
        addr_b = addr_a | half;
        tw_m   = 5'((6'(jpos) << (3'd5 - stg_reg)));
        {tw_c, tw_s} = twiddle(tw_m);
    end

    // Single read port, registered. While a bin is stalled, re-read the held
    // entry so the read data stays on the bin that waits.
    always_comb begin
        rd_addr = idx_reg[AW-1:0];
        unique case (state_reg)
            ST_BRV:  rd_addr = (brp_reg == 2'd0) ? idx_reg[AW-1:0] : rev_idx;
            ST_RDA:  rd_addr = addr_a;
            ST_RDB:  rd_addr = addr_b;
            ST_OUT:  rd_addr = (rd_pend_reg && !out_free) ? idx_reg[AW-1:0] - AW'(1)
                                                           : idx_reg[AW-1:0];
            default: rd_addr = idx_reg[AW-1:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        rd_re_reg <= mem_re[rd_addr];
        rd_im_reg <= mem_im[rd_addr];
    end

    function automatic logic signed [BW-1:0] rnd(input logic signed [BW+17:0] p);
        logic signed [BW+17:0] t;
        t = (p + (BW+18)'(1 << (TW_SHIFT-1))) >>> TW_SHIFT;
        return t[BW-1:0];
    endfunction

    logic signed [BW-1:0] o_re, o_im;
    logic signed [BW:0]   sr, si, rr, ri;
    always_comb begin
        sr = {rd_re_reg[BW-1], rd_re_reg};
        si = -{rd_im_reg[BW-1], rd_im_reg};
        o_re = rd_re_reg;
        o_im = rd_im_reg;
        rr = '0;
        ri = '0;
        if (job_reg.inv) begin
            if (job_reg.k != 3'd0) begin
                rr = (sr + ((BW+1)'(1) << (job_reg.k - 3'd1))) >>> job_reg.k;
                ri = (si + ((BW+1)'(1) << (job_reg.k - 3'd1))) >>> job_reg.k;
                o_re = rr[BW-1:0];
                o_im = ri[BW-1:0];
            end else begin
                o_im = si[BW-1:0];
            end
        end
    end

    logic [AW:0] last_t;
    assign last_t = (n_pts >> 1) - (AW+1)'(1);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (job_valid) state_next = ST_BRV;
            ST_BRV:  if (idx_reg == n_pts && brp_reg == 2'd0)
                         state_next = (job_reg.k == 3'd0) ? ST_OUT : ST_RDA;
            ST_RDA:  state_next = ST_RDB;
            ST_RDB:  state_next = ST_MUL;
            ST_MUL:  if (mulp_reg) state_next = ST_WR;
            ST_WR:   if (idx_reg == last_t && stg_reg == job_reg.k - 3'd1)
                         state_next = ST_OUT;
                     else
                         state_next = ST_RDA;
            ST_OUT:  if (rd_pend_reg && out_free && idx_reg == n_pts)
                         state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_re[wr_addr] <= BW'(wr_re);
            mem_im[wr_addr] <= BW'(wr_im);
        end else if (state_reg == ST_BRV && brp_reg == 2'd2) begin
            // swap: rev_idx gets element i (held in ar/ai), i gets element r
            mem_re[rev_idx] <= ar_reg;
            mem_im[rev_idx] <= ai_reg;
        end else if (state_reg == ST_BRV && brp_reg == 2'd3) begin
            mem_re[idx_reg[AW-1:0]] <= br_reg;
            mem_im[idx_reg[AW-1:0]] <= bi_reg;
        end else if (state_reg == ST_MUL && mulp_reg) begin
            mem_re[addr_a] <= ar_reg + tr_reg;
            mem_im[addr_a] <= ai_reg + ti_reg;
        end else if (state_reg == ST_WR) begin
            mem_re[addr_b] <= ar_reg - tr_reg;
            mem_im[addr_b] <= ai_reg - ti_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            stg_reg     <= '0;
            brp_reg     <= '0;
            mulp_reg    <= 1'b0;
            ovalid_reg  <= 1'b0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ovalid_reg && m_ready) ovalid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    idx_reg <= '0;
                    stg_reg <= '0;
                    brp_reg <= '0;
                    rd_pend_reg <= 1'b0;
                    if (job_valid) job_reg <= job;
                end
                ST_BRV: begin
                    // step 0: read i; 1: read r; 2: write r; 3: write i
                    if (brp_reg == 2'd0) begin
                        if (idx_reg == n_pts) begin
                            idx_reg <= '0;
                        end else if (idx_reg[AW-1:0] < rev_idx) begin
                            brp_reg <= 2'd1;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end else if (brp_reg == 2'd1) begin
                        ar_reg  <= rd_re_reg;
                        ai_reg  <= rd_im_reg;
                        brp_reg <= 2'd2;
                    end else if (brp_reg == 2'd2) begin
                        br_reg  <= rd_re_reg;
                        bi_reg  <= rd_im_reg;
                        brp_reg <= 2'd3;
                    end else begin
                        brp_reg <= 2'd0;
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_RDA: mulp_reg <= 1'b0;
                ST_RDB: begin
                    ar_reg <= rd_re_reg;
                    ai_reg <= rd_im_reg;
                end
                ST_MUL: begin
                    if (!mulp_reg) begin
                        p_rc_reg <= rd_re_reg * tw_c;
                        p_is_reg <= rd_im_reg * tw_s;
                        p_ic_reg <= rd_im_reg * tw_c;
                        p_rs_reg <= rd_re_reg * tw_s;
                    end
                    mulp_reg <= !mulp_reg;
                end
                ST_WR: begin
                    if (idx_reg == last_t) begin
                        idx_reg <= '0;
                        stg_reg <= stg_reg + 3'd1;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_OUT: begin
                    if (!rd_pend_reg) begin
                        rd_pend_reg <= 1'b1;
                        idx_reg     <= idx_reg + 1'b1;
                    end else if (out_free) begin
                        ovalid_reg <= 1'b1;
                        ore_reg    <= o_re;
                        oim_reg    <= o_im;
                        olast_reg  <= (idx_reg == n_pts);
                        if (idx_reg != n_pts) idx_reg <= idx_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Rounded twiddle products, combined from the product registers; valid once mulp is set in MUL.
    always_comb begin
        tr_reg = rnd(p_rc_reg) + rnd(p_is_reg);
        ti_reg = rnd(p_ic_reg) - rnd(p_rs_reg);
    end

    assign m_valid    = ovalid_reg;
    assign m_bin_real = ore_reg;
    assign m_bin_imag = oim_reg;
    assign m_last_bin = olast_reg;

    // The store is never loaded while a transform runs.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !wr_en)
        else $error("sample load during transform");
    // A held bin is not overwritten.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_bin_real) && $stable(m_bin_imag))
        else $error("bin changed while stalled");
    // A job is only issued when the engine is idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid |-> (state_reg == ST_IDLE))
        else $error("job issued to busy engine");

endmodule

@@ src/radix2_fft_with_inverse.sv @@
// Top level of the radix-2 FFT / inverse FFT block.
// Usage:
//  - Input channel s_valid/s_ready moves one complex sample per transfer.
//  - After 2^min(size_log2, log2(MAX_POINTS)) samples the transform runs over
//    the store; s_ready is low until the last bin sits in the output register.
//  - Result channel m_valid/m_ready moves one bin per transfer in index
//    order; m_last_bin marks the final bin of a transform.
//  - Config channel cfg_valid/cfg_ready writes size_log2 (index 0) or
//    inverse_mode (index 1); write only while idle. cfg_ready is always high.
//  - Sequence: samples load into the point store, then bit reversal swaps
//    index pairs, then (N/2)*log2(N) butterflies run on the single store
//    read port (read a, read b, multiply, write a and b), then bins go out
//    one per cycle while m_ready stays high, after a read prime.
//  - A one-point transform returns the sample itself.
//  - Reset clears the fill count and configuration (size 64, forward).
//  - When the receiver stalls, the held bin stays put and the engine waits.
module radix2_fft_with_inverse
    import r2fft_pkg::*;
#(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [SAMPLE_BITS-1:0]   s_sample_real,
    input  logic signed [SAMPLE_BITS-1:0]   s_sample_imag,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [SAMPLE_BITS+5:0]   m_bin_real,
    output logic signed [SAMPLE_BITS+5:0]   m_bin_imag,
    output logic                            m_last_bin,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [2:0]                      cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);

    logic [2:0] size_reg;
    logic       inv_reg;

    assign cfg_ready = 1'b1;

    // Take configuration writes; index picks the register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= 3'd6;
            inv_reg  <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SIZE_LOG2:    size_reg <= cfg_data;
                CFG_INVERSE_MODE: inv_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic                          eng_busy, wr_en, job_valid;
    logic [AW-1:0]                 wr_addr;
    logic signed [SAMPLE_BITS-1:0] wr_re;
    logic signed [SAMPLE_BITS:0]   wr_im;
    r2fft_job_t                    job;

    r2fft_front #(.MAX_POINTS(MAX_POINTS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_sample_real, .s_sample_imag,
        .size_log2(size_reg), .inverse_mode(inv_reg), .eng_busy,
        .wr_en, .wr_addr, .wr_re, .wr_im, .job_valid, .job
    );

    r2fft_engine #(.MAX_POINTS(MAX_POINTS), .SAMPLE_BITS(SAMPLE_BITS)) u_engine (
        .aclk, .aresetn, .wr_en, .wr_addr, .wr_re, .wr_im, .job_valid, .job,
        .busy(eng_busy), .m_valid, .m_ready, .m_bin_real, .m_bin_imag, .m_last_bin
    );

endmodule
